// ===== rtl/core/serial_frame_receiver_xor_top_assert.svh =====
// Assertion macros for the serial frame receiver checker.
// Needs nothing else; included by the checker file by bare name.
`ifndef SERIAL_FRAME_RECEIVER_XOR_TOP_ASSERT_SVH
`define SERIAL_FRAME_RECEIVER_XOR_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is held
`define SFRX_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held
`define SFRX_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/sfrx_pkg.sv =====
// Shared types and constants of the serial frame receiver.
// No dependencies; imported by the parser, the replay unit and the top level.
package sfrx_pkg;

    // Parser phases
    typedef enum logic [2:0] {
        PH_HUNT  = 3'd0,
        PH_CMD   = 3'd1,
        PH_LEN   = 3'd2,
        PH_DATA  = 3'd3,
        PH_CHECK = 3'd4
    } sfrx_phase_t;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_START_BYTE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KIND0_ID   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KIND0_LEN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KIND1_ID   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KIND1_LEN  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_KIND2_ID   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_KIND2_LEN  = 3'd6;

    localparam int NUM_KINDS = 3;
    localparam int KLEN_W    = 6;

    // Configuration register file contents
    typedef struct packed {
        logic [7:0]                          start_byte;
        logic [NUM_KINDS-1:0][7:0]           kind_id;
        logic [NUM_KINDS-1:0][KLEN_W-1:0]    kind_len;
    } sfrx_cfg_t;

    localparam sfrx_cfg_t CFG_RESET = '{
        start_byte: 8'd170,
        kind_id:    {8'd3, 8'd2, 8'd1},
        kind_len:   {6'd1, 6'd1, 6'd1}
    };

    // Replay request from parser to replay unit
    typedef struct packed {
        logic       go;
        logic [1:0] kind;
    } sfrx_req_t;

    // One result item
    typedef struct packed {
        logic [1:0] kind;
        logic [4:0] index;
        logic [7:0] data;
        logic       last;
    } sfrx_item_t;

endpackage

// ===== rtl/core/sfrx_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module sfrx_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end
endmodule

// ===== rtl/core/sfrx_parser.sv =====
// Byte-wise frame parser: tracks the phase, writes the payload into the
// store and checks checksum and record kind. Depends on sfrx_pkg.
module sfrx_parser #(
    parameter int BUFFER_BYTES = 32,
    parameter int LEN_W        = 6,
    parameter int ADDR_W       = 5
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                byte_accept,
    input  logic [7:0]          rx_byte,
    input  sfrx_pkg::sfrx_cfg_t cfg,
    output logic                ram_we,
    output logic [ADDR_W-1:0]   ram_waddr,
    output logic [7:0]          ram_wdata,
    output sfrx_pkg::sfrx_req_t req,
    output logic [LEN_W-1:0]    req_len
);
    import sfrx_pkg::*;

    sfrx_phase_t      phase_reg, phase_next;
    logic [7:0]       cmd_reg, cmd_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [LEN_W-1:0] fill_reg, fill_next;
    logic [7:0]       xor_reg, xor_next;

    logic [LEN_W-1:0] fill_inc;
    logic             len_ok;
    logic [2:0]       kind_hit;
    logic             kind_any;
    logic [1:0]       kind_sel;

    // Compare the frame against each configured record kind
    always_comb begin
        for (int k = 0; k < NUM_KINDS; k++) begin
            kind_hit[k] = (cmd_reg == cfg.kind_id[k]) &&
                          (8'(len_reg) == 8'(cfg.kind_len[k]));
        end
    end

    // Lowest kind wins
    assign kind_any = |kind_hit;
    always_comb begin
        if (kind_hit[0]) begin
            kind_sel = 2'd0;
        end else if (kind_hit[1]) begin
            kind_sel = 2'd1;
        end else begin
            kind_sel = 2'd2;
        end
    end

    assign fill_inc = fill_reg + LEN_W'(1);
    assign len_ok   = (rx_byte != 8'd0) && ({1'b0, rx_byte} <= 9'(BUFFER_BYTES));

    // Next phase and frame state
    always_comb begin
        phase_next = phase_reg;
        cmd_next   = cmd_reg;
        len_next   = len_reg;
        fill_next  = fill_reg;
        xor_next   = xor_reg;
        ram_we     = 1'b0;
        req.go     = 1'b0;
        req.kind   = kind_sel;
        if (byte_accept) begin
            case (phase_reg)
                PH_CMD: begin
                    cmd_next   = rx_byte;
                    phase_next = PH_LEN;
                end
                PH_LEN: begin
                    fill_next  = '0;
                    xor_next   = 8'd0;
                    len_next   = LEN_W'(rx_byte);
                    phase_next = len_ok ? PH_DATA : PH_HUNT;
                end
                PH_DATA: begin
                    ram_we    = 1'b1;
                    xor_next  = xor_reg ^ rx_byte;
                    fill_next = fill_inc;
                    if (fill_inc >= len_reg) begin
                        phase_next = PH_CHECK;
                    end
                end
                PH_CHECK: begin
                    req.go     = (rx_byte == xor_reg) && kind_any;
                    phase_next = PH_HUNT;
                end
                default: begin
                    phase_next = (rx_byte == cfg.start_byte) ? PH_CMD : PH_HUNT;
                end
            endcase
        end
    end

    assign ram_waddr = fill_reg[ADDR_W-1:0];
    assign ram_wdata = rx_byte;
    assign req_len   = len_reg;

    // Hold parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HUNT;
            cmd_reg   <= 8'd0;
            len_reg   <= '0;
            fill_reg  <= '0;
            xor_reg   <= 8'd0;
        end else begin
            phase_reg <= phase_next;
            cmd_reg   <= cmd_next;
            len_reg   <= len_next;
            fill_reg  <= fill_next;
            xor_reg   <= xor_next;
        end
    end
endmodule

// ===== rtl/core/sfrx_replay.sv =====
// Payload replay: reads the store one entry per cycle while the output buffer has room and
// queues the items in a two-entry output buffer. Depends on sfrx_pkg.
module sfrx_replay #(
    parameter int LEN_W  = 6,
    parameter int ADDR_W = 5
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  sfrx_pkg::sfrx_req_t  req,
    input  logic [LEN_W-1:0]     req_len,
    output logic                 ram_re,
    output logic [ADDR_W-1:0]    ram_raddr,
    input  logic [7:0]           ram_rdata,
    output logic                 out_valid,
    input  logic                 out_ready,
    output sfrx_pkg::sfrx_item_t out_item,
    output logic                 busy
);
    import sfrx_pkg::*;

    logic             active_reg, active_next;
    logic [LEN_W-1:0] rd_idx_reg, rd_idx_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [1:0]       kind_reg, kind_next;
    logic             infl_reg, infl_next;
    logic [LEN_W-1:0] infl_idx_reg, infl_idx_next;
    logic [1:0]       occ_reg, occ_next;
    sfrx_item_t       ent0_reg, ent0_next;
    sfrx_item_t       ent1_reg, ent1_next;

    logic             pop;
    logic             push;
    logic             issue;
    logic [LEN_W-1:0] rd_inc;
    sfrx_item_t       new_item;

    assign pop   = (occ_reg != 2'd0) && out_ready;
    assign push  = infl_reg;
    // Issue a read only when the buffer has room for it on arrival
    assign issue = active_reg &&
                   ((3'(occ_reg) + 3'(infl_reg) - 3'(pop)) < 3'd2);
    assign rd_inc = rd_idx_reg + LEN_W'(1);

    assign ram_re    = issue;
    assign ram_raddr = rd_idx_reg[ADDR_W-1:0];

    // Item built from the read data that lands this cycle
    always_comb begin
        new_item.kind  = kind_reg;
        new_item.index = 5'(infl_idx_reg);
        new_item.data  = ram_rdata;
        new_item.last  = ((LEN_W+1)'(infl_idx_reg) + (LEN_W+1)'(1)) ==
                         (LEN_W+1)'(len_reg);
    end

    // Advance the read pointer
    always_comb begin
        active_next   = active_reg;
        rd_idx_next   = rd_idx_reg;
        len_next      = len_reg;
        kind_next     = kind_reg;
        infl_next     = issue;
        infl_idx_next = issue ? rd_idx_reg : infl_idx_reg;
        if (req.go) begin
            active_next = 1'b1;
            rd_idx_next = '0;
            len_next    = req_len;
            kind_next   = req.kind;
        end else if (issue) begin
            rd_idx_next = rd_inc;
            if (rd_inc == len_reg) begin
                active_next = 1'b0;
            end
        end
    end

    // Output buffer: entry 0 is presented on the port
    always_comb begin
        ent0_next = ent0_reg;
        ent1_next = ent1_reg;
        occ_next  = occ_reg;
        case ({push, pop})
            2'b10: begin
                if (occ_reg == 2'd0) begin
                    ent0_next = new_item;
                end else begin
                    ent1_next = new_item;
                end
                occ_next = occ_reg + 2'd1;
            end
            2'b01: begin
                ent0_next = ent1_reg;
                occ_next  = occ_reg - 2'd1;
            end
            2'b11: begin
                if (occ_reg == 2'd1) begin
                    ent0_next = new_item;
                end else begin
                    ent0_next = ent1_reg;
                    ent1_next = new_item;
                end
            end
            default: begin
                occ_next = occ_reg;
            end
        endcase
    end

    assign out_valid = (occ_reg != 2'd0);
    assign out_item  = ent0_reg;
    assign busy      = active_reg || infl_reg || (occ_reg != 2'd0);

    // Hold control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            infl_reg   <= 1'b0;
            occ_reg    <= 2'd0;
        end else begin
            active_reg <= active_next;
            infl_reg   <= infl_next;
            occ_reg    <= occ_next;
        end
    end

    // Hold payload registers
    always_ff @(posedge aclk) begin
        rd_idx_reg   <= rd_idx_next;
        len_reg      <= len_next;
        kind_reg     <= kind_next;
        infl_idx_reg <= infl_idx_next;
        ent0_reg     <= ent0_next;
        ent1_reg     <= ent1_next;
    end
endmodule

// ===== rtl/core/serial_frame_receiver_xor_top.sv =====
// Serial frame receiver with XOR checksum: top level.
// Depends on sfrx_pkg, sfrx_ram, sfrx_parser and sfrx_replay.
//
// Usage:
//   s_* carries one received byte per transfer (s_tdata). Frames are
//   start byte, command id, length, payload and an XOR checksum of the
//   payload. m_* replays the payload of each good frame whose id and length
//   match a configured record kind: m_tuser = kind, m_tdata = byte index
//   and payload byte, m_tlast on the final byte.
//   cfg_* writes the seven configuration registers; cfg_ready is always
//   high. Write them only while no frame is being replayed.
// Input and replay:
//   One byte is taken per cycle while no replay is running. A checksum
//   byte that completes a matching frame starts a replay: the replay unit
//   registers the request, reads the store and buffers each byte, and results
//   follow one per cycle while m_tready stays high, set by the single read
//   port of the payload store. s_tready stays low until the last result is
//   transferred, so the store is never read and written at once.
// Reset and stalls:
//   aresetn (synchronous, active low) returns the parser to hunting for a
//   start byte, empties the output buffer and loads the register defaults.
//   A low m_tready holds the current result and pauses the store reads once the output buffer is full.
module serial_frame_receiver_xor_top #(
    parameter int BUFFER_BYTES = 32
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [7:0]                         s_tdata,    // [7:0] rx_byte
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [15:0]                        m_tdata,    // [4:0] byte_index,
                                                           // [12:5] payload_byte
    output logic [1:0]                         m_tuser,    // [1:0] record_kind
    output logic                               m_tlast,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [sfrx_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [7:0]                         cfg_data
);
    import sfrx_pkg::*;

    localparam int LEN_W  = $clog2(BUFFER_BYTES + 1);
    localparam int ADDR_W = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;

    sfrx_cfg_t        cfg_reg, cfg_next;
    logic             s_accept;
    logic             ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [7:0]       ram_wdata;
    logic             ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [7:0]       ram_rdata;
    sfrx_req_t        req;
    logic [LEN_W-1:0] req_len;
    sfrx_item_t       item;
    logic             busy;

    // Configuration register file
    assign cfg_ready = 1'b1;
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_START_BYTE: cfg_next.start_byte  = cfg_data;
                REG_KIND0_ID:   cfg_next.kind_id[0]  = cfg_data;
                REG_KIND0_LEN:  cfg_next.kind_len[0] = cfg_data[KLEN_W-1:0];
                REG_KIND1_ID:   cfg_next.kind_id[1]  = cfg_data;
                REG_KIND1_LEN:  cfg_next.kind_len[1] = cfg_data[KLEN_W-1:0];
                REG_KIND2_ID:   cfg_next.kind_id[2]  = cfg_data;
                REG_KIND2_LEN:  cfg_next.kind_len[2] = cfg_data[KLEN_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Hold off input while a replay owns the store
    assign s_tready = !busy;
    assign s_accept = s_tvalid && s_tready;

    sfrx_parser #(
        .BUFFER_BYTES (BUFFER_BYTES),
        .LEN_W        (LEN_W),
        .ADDR_W       (ADDR_W)
    ) u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .byte_accept (s_accept),
        .rx_byte     (s_tdata),
        .cfg         (cfg_reg),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .req         (req),
        .req_len     (req_len)
    );

    sfrx_ram #(
        .WIDTH  (8),
        .DEPTH  (BUFFER_BYTES),
        .ADDR_W (ADDR_W)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    sfrx_replay #(
        .LEN_W  (LEN_W),
        .ADDR_W (ADDR_W)
    ) u_replay (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req       (req),
        .req_len   (req_len),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_item  (item),
        .busy      (busy)
    );

    // Pack the result fields
    assign m_tdata = {3'b000, item.data, item.index};
    assign m_tuser = item.kind;
    assign m_tlast = item.last;
endmodule

// ===== rtl/core/sfrx_checker.sv =====
// Port-level checker for the serial frame receiver, bound to the top level.
// Depends on serial_frame_receiver_xor_top_assert.svh.
`include "serial_frame_receiver_xor_top_assert.svh"

module sfrx_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast,
    input logic        cfg_valid,
    input logic        cfg_ready,
    input logic [2:0]  cfg_index,
    input logic [7:0]  cfg_data
);
    // A stalled result must hold
    `SFRX_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "result changed while stalled")

    // No byte is taken while a result waits
    `SFRX_ASSERT_NOW(a_no_input_during_replay, aclk, aresetn, m_tvalid, !s_tready, "input ready during replay")

    // A replay runs on until its last byte is transferred
    `SFRX_ASSERT_NEXT(a_replay_continues, aclk, aresetn, m_tvalid && m_tready && !m_tlast, !s_tready, "replay ended before last byte")

    // Only three record kinds exist
    `SFRX_ASSERT_NOW(a_kind_range, aclk, aresetn, m_tvalid, m_tuser != 2'd3, "record kind out of range")
endmodule

bind serial_frame_receiver_xor_top sfrx_checker u_sfrx_checker (.*);
